### sv/ptpd_pkg.sv
// Shared types and constants for the perspective-divide point transform.
package ptpd_pkg;

	localparam int FRAC_BITS = 16;
	// Row sums need 66 signed bits; magnitudes fit in 64.
	localparam int SUM_W = 66;
	localparam int MAG_W = 64;
	// Quotient bits produced by the divider, one per stage.
	localparam int QUO_W = 32;
	// Remainder width: holds a magnitude shifted by FRAC_BITS and a divisor shifted by QUO_W.
	localparam int REM_W = MAG_W + QUO_W;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_XFORM = 1'b1;

	typedef struct packed {
		logic op;
		logic [3:0] entry_index;
		logic signed [31:0] entry_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic w_zero;
		logic saturated;
	} out_word_t;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] num_mag;
		logic [MAG_W-1:0] den_mag;
		logic [2:0] neg;
		logic w_zero;
	} entry_t;

endpackage

### sv/ptpd_front.sv
// Front end: matrix store, row dot products and sign/magnitude split.
module ptpd_front (
	input  logic clk,
	input  logic arst_n,
	input  logic pt_valid,
	output logic pt_stall,
	input  ptpd_pkg::in_word_t pt_data,
	output logic push_valid,
	input  logic push_full,
	output ptpd_pkg::entry_t push_data
);

	logic signed [31:0] mat_q [16];
	logic en;
	logic acc;
	logic signed [31:0] pt [3];
	logic signed [63:0] prod_d [4][3];
	logic signed [63:0] prod_s1 [4][3];
	logic signed [ptpd_pkg::SUM_W-1:0] bias_s1 [4];
	logic v_s1;
	logic signed [ptpd_pkg::SUM_W-1:0] sum_s2 [4];
	logic v_s2;
	ptpd_pkg::entry_t ent_d;
	ptpd_pkg::entry_t ent_s3;
	logic v_s3;

	// The whole front moves together; it halts only when its last word cannot enter the queue.
	assign en = !(v_s3 && push_full);
	assign pt_stall = !en;
	assign acc = pt_valid && en;
	assign push_valid = v_s3;
	assign push_data = ent_s3;

	assign pt[0] = pt_data.point_x;
	assign pt[1] = pt_data.point_y;
	assign pt[2] = pt_data.point_z;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_d[r][c] = mat_q[r*4+c] * pt[c];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ent_d.neg[c] = sum_s2[c][ptpd_pkg::SUM_W-1] ^ sum_s2[3][ptpd_pkg::SUM_W-1];
			ent_d.num_mag[c] = sum_s2[c][ptpd_pkg::SUM_W-1] ?
				ptpd_pkg::MAG_W'(-sum_s2[c]) : ptpd_pkg::MAG_W'(sum_s2[c]);
		end
		ent_d.den_mag = sum_s2[3][ptpd_pkg::SUM_W-1] ?
			ptpd_pkg::MAG_W'(-sum_s2[3]) : ptpd_pkg::MAG_W'(sum_s2[3]);
		ent_d.w_zero = (sum_s2[3] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= (i % 5 == 0) ? 32'(1) <<< ptpd_pkg::FRAC_BITS : '0;
			end
		end else if (acc && pt_data.op == ptpd_pkg::OP_LOAD) begin
			mat_q[pt_data.entry_index] <= pt_data.entry_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && pt_data.op == ptpd_pkg::OP_XFORM;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_d;
			for (int r = 0; r < 4; r++) begin
				bias_s1[r] <= ptpd_pkg::SUM_W'(mat_q[r*4+3]) <<< ptpd_pkg::FRAC_BITS;
				sum_s2[r] <= ptpd_pkg::SUM_W'(prod_s1[r][0]) + ptpd_pkg::SUM_W'(prod_s1[r][1])
					+ ptpd_pkg::SUM_W'(prod_s1[r][2]) + bias_s1[r];
			end
			ent_s3 <= ent_d;
		end
	end

endmodule

### sv/ptpd_queue.sv
// Small register FIFO between the front end and the divider.
module ptpd_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ptpd_pkg::entry_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output ptpd_pkg::entry_t pop_data
);

	ptpd_pkg::entry_t mem_q [ptpd_pkg::Q_DEPTH];
	logic [ptpd_pkg::Q_AW-1:0] wr_q;
	logic [ptpd_pkg::Q_AW-1:0] rd_q;
	logic [ptpd_pkg::Q_AW:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = (cnt_q == (ptpd_pkg::Q_AW+1)'(ptpd_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (ptpd_pkg::Q_AW+1)'(do_push) - (ptpd_pkg::Q_AW+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

### sv/ptpd_back.sv
// Back end: overflow check, pipelined restoring divider and output register.
module ptpd_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  ptpd_pkg::entry_t q_data,
	output logic q_pop,
	output logic res_valid,
	input  logic res_stall,
	output ptpd_pkg::out_word_t res_data
);

	localparam int NS = ptpd_pkg::QUO_W + 1;

	logic en;
	logic v_q [NS];
	logic [ptpd_pkg::REM_W-1:0] rem_q [NS][3];
	logic [ptpd_pkg::QUO_W-1:0] quo_q [NS][3];
	logic [ptpd_pkg::MAG_W-1:0] den_q [NS];
	logic [2:0] neg_q [NS];
	logic [2:0] ovf_q [NS];
	logic wz_q [NS];
	logic [ptpd_pkg::REM_W-1:0] rem_d [NS][3];
	logic [ptpd_pkg::QUO_W-1:0] quo_d [NS][3];
	logic [ptpd_pkg::REM_W-1:0] den_sh;
	logic [ptpd_pkg::REM_W-1:0] lim;
	logic [2:0] ovf_d;
	logic [ptpd_pkg::QUO_W-1:0] res_c [3];
	logic out_v_q;
	ptpd_pkg::out_word_t out_q;

	assign en = !out_v_q || !res_stall;
	assign q_pop = en && !q_empty;
	assign res_valid = out_v_q;
	assign res_data = out_q;

	// A quotient saturates when num*2^F >= 2^31*den, or >= (2^31+1)*den when negative.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			lim = (ptpd_pkg::REM_W'(q_data.den_mag) << (ptpd_pkg::QUO_W - 1))
				+ (q_data.neg[c] ? ptpd_pkg::REM_W'(q_data.den_mag) : '0);
			ovf_d[c] = rem_d[0][c] >= lim;
		end
	end

	// Stage k settles quotient bit QUO_W-1-k for all three channels.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rem_d[0][c] = ptpd_pkg::REM_W'(q_data.num_mag[c]) << ptpd_pkg::FRAC_BITS;
			quo_d[0][c] = '0;
		end
		for (int k = 0; k < NS - 1; k++) begin
			den_sh = ptpd_pkg::REM_W'(den_q[k]) << (ptpd_pkg::QUO_W - 1 - k);
			for (int c = 0; c < 3; c++) begin
				quo_d[k+1][c] = quo_q[k][c];
				if (rem_q[k][c] >= den_sh) begin
					rem_d[k+1][c] = rem_q[k][c] - den_sh;
					quo_d[k+1][c][ptpd_pkg::QUO_W-1-k] = 1'b1;
				end else begin
					rem_d[k+1][c] = rem_q[k][c];
				end
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (wz_q[NS-1]) begin
				res_c[c] = '0;
			end else if (ovf_q[NS-1][c]) begin
				res_c[c] = neg_q[NS-1][c] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else begin
				res_c[c] = neg_q[NS-1][c] ? -quo_q[NS-1][c] : quo_q[NS-1][c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				v_q[k] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (en) begin
			v_q[0] <= !q_empty;
			for (int k = 1; k < NS; k++) begin
				v_q[k] <= v_q[k-1];
			end
			out_v_q <= v_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= q_data.den_mag;
			neg_q[0] <= q_data.neg;
			ovf_q[0] <= ovf_d;
			wz_q[0] <= q_data.w_zero;
			for (int k = 0; k < NS; k++) begin
				for (int c = 0; c < 3; c++) begin
					rem_q[k][c] <= rem_d[k][c];
					quo_q[k][c] <= quo_d[k][c];
				end
			end
			for (int k = 1; k < NS; k++) begin
				den_q[k] <= den_q[k-1];
				neg_q[k] <= neg_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
				wz_q[k] <= wz_q[k-1];
			end
			out_q.out_x <= res_c[0];
			out_q.out_y <= res_c[1];
			out_q.out_z <= res_c[2];
			out_q.w_zero <= wz_q[NS-1];
			out_q.saturated <= !wz_q[NS-1] && (ovf_q[NS-1] != '0);
		end
	end

endmodule

### sv/point_transform_perspective_divide.sv
// Homogeneous 4x4 point transform with perspective divide, signed Q16.16 throughout.
// A word with op=0 writes one matrix entry and gives no result; a word with op=1
// transforms a point and gives one result. The unit takes one word per clock when the result
// side does not stall. A point passes three front stages (multiply, row sum, sign split), a
// four-word queue, one overflow-check stage, a 32-stage restoring divider (one quotient bit per
// stage for x, y and z together) and the output register. The queue lets the front keep
// taking words while the result side stalls, until the queue fills.
module point_transform_perspective_divide (
	input  logic clk,
	input  logic arst_n,
	input  logic pt_valid,
	output logic pt_stall,
	input  ptpd_pkg::in_word_t pt_data,
	output logic res_valid,
	input  logic res_stall,
	output ptpd_pkg::out_word_t res_data
);

	logic push_valid;
	logic q_full;
	logic q_empty;
	logic q_pop;
	ptpd_pkg::entry_t push_data;
	ptpd_pkg::entry_t q_data;

	ptpd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pt_valid(pt_valid),
		.pt_stall(pt_stall),
		.pt_data(pt_data),
		.push_valid(push_valid),
		.push_full(q_full),
		.push_data(push_data)
	);

	ptpd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push_valid),
		.push_data(push_data),
		.full(q_full),
		.pop(q_pop),
		.empty(q_empty),
		.pop_data(q_data)
	);

	ptpd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(q_data),
		.q_pop(q_pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

`ifndef SYNTHESIS
	a_wz_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.w_zero && res_data.saturated))
		else $error("w_zero and saturated both set");
	a_wz_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.w_zero |->
			res_data.out_x == '0 && res_data.out_y == '0 && res_data.out_z == '0)
		else $error("zero w with nonzero outputs");
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue both full and empty");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pt_stall |-> q_full)
		else $error("front stalled without a full queue");
`endif

endmodule

### sim/ptpd_checker.sv
// Checker for the perspective-divide point transform: predicts each result and compares it.
`timescale 1ns / 100ps
module ptpd_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic pt_valid,
	input  logic pt_stall,
	input  ptpd_pkg::in_word_t pt_data,
	input  logic res_valid,
	input  logic res_stall,
	input  ptpd_pkg::out_word_t res_data,
	output int fail_count,
	output int pending,
	output int points_seen,
	output int sat_seen,
	output int wz_seen
);

	logic signed [31:0] matrix [16];
	ptpd_pkg::out_word_t expected_q [$];

	// Exact row sum at 2*FRAC_BITS fraction bits.
	function automatic logic signed [127:0] row_sum(int r, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		logic signed [127:0] s;
		s = 128'(matrix[r*4+3]) <<< ptpd_pkg::FRAC_BITS;
		s = s + 128'(matrix[r*4+0]) * 128'(x);
		s = s + 128'(matrix[r*4+1]) * 128'(y);
		s = s + 128'(matrix[r*4+2]) * 128'(z);
		return s;
	endfunction

	function automatic logic [31:0] scaled_quotient(logic signed [127:0] num,
			logic signed [127:0] den, inout logic sat);
		logic neg;
		logic [127:0] a, b, q;
		neg = num[127] ^ den[127];
		a = num[127] ? -num : num;
		b = den[127] ? -den : den;
		q = (a << ptpd_pkg::FRAC_BITS) / b;
		if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
			sat = 1'b1;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		return neg ? 32'(-q) : q[31:0];
	endfunction

	function automatic ptpd_pkg::out_word_t transform_point(ptpd_pkg::in_word_t w);
		ptpd_pkg::out_word_t o;
		logic signed [127:0] sw;
		logic sat;
		sat = 1'b0;
		o = '0;
		sw = row_sum(3, w.point_x, w.point_y, w.point_z);
		if (sw == 0) begin
			o.w_zero = 1'b1;
			return o;
		end
		o.out_x = scaled_quotient(row_sum(0, w.point_x, w.point_y, w.point_z), sw, sat);
		o.out_y = scaled_quotient(row_sum(1, w.point_x, w.point_y, w.point_z), sw, sat);
		o.out_z = scaled_quotient(row_sum(2, w.point_x, w.point_y, w.point_z), sw, sat);
		o.saturated = sat;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ptpd_pkg::out_word_t e;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				matrix[i] <= (i % 5 == 0) ? (32'sd1 <<< ptpd_pkg::FRAC_BITS) : 32'sd0;
			expected_q.delete();
			fail_count <= 0;
			pending <= 0;
			points_seen <= 0;
			sat_seen <= 0;
			wz_seen <= 0;
		end else begin
			if (pt_valid && !pt_stall) begin
				if (pt_data.op == ptpd_pkg::OP_LOAD) begin
					matrix[pt_data.entry_index] <= pt_data.entry_value;
				end else begin
					e = transform_point(pt_data);
					expected_q.push_back(e);
					points_seen <= points_seen + 1;
					if (e.saturated) sat_seen <= sat_seen + 1;
					if (e.w_zero) wz_seen <= wz_seen + 1;
				end
			end
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, res_data);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_q.pop_front();
					if (e !== res_data) begin
						$display("%0t: mismatch expected x=%h y=%h z=%h wz=%b sat=%b", $time,
							e.out_x, e.out_y, e.out_z, e.w_zero, e.saturated);
						$display("%0t:          actual   x=%h y=%h z=%h wz=%b sat=%b", $time,
							res_data.out_x, res_data.out_y, res_data.out_z,
							res_data.w_zero, res_data.saturated);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end
endmodule

### sim/point_transform_perspective_divide_test.sv
// Top of the point transform testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module point_transform_perspective_divide_test;

	localparam int RANDOM_WORDS = 1850;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pt_valid = 1'b0;
	logic pt_stall;
	ptpd_pkg::in_word_t pt_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ptpd_pkg::out_word_t res_data;
	int fail_count, pending, points_seen, sat_seen, wz_seen;
	logic long_hold = 1'b0;
	logic signed [31:0] corner [6] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0,
		32'sh0001_0000, -32'sh0001_0000, 32'sd1};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	point_transform_perspective_divide u_top (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_stall(pt_stall), .pt_data(pt_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
	);

	ptpd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.pt_valid(pt_valid), .pt_stall(pt_stall), .pt_data(pt_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.fail_count(fail_count), .pending(pending), .points_seen(points_seen),
		.sat_seen(sat_seen), .wz_seen(wz_seen)
	);

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return corner[$urandom_range(0, 5)];
			1: return $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
			2: return $signed(32'($urandom_range(0, 32'h0200_0000))) - 32'sh0100_0000;
			default: return $urandom;
		endcase
	endfunction

	// Offers one word and holds it until it is taken.
	task automatic send_word(ptpd_pkg::in_word_t w);
		pt_valid <= 1'b1;
		pt_data <= w;
		@(posedge clk);
		while (pt_stall) @(posedge clk);
	endtask

	task automatic idle_cycles(int n);
		pt_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_load(int idx, logic signed [31:0] v);
		ptpd_pkg::in_word_t w;
		w = '0;
		w.op = ptpd_pkg::OP_LOAD;
		w.entry_index = 4'(idx);
		w.entry_value = v;
		w.point_x = $urandom;
		w.point_y = $urandom;
		w.point_z = $urandom;
		send_word(w);
	endtask

	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		ptpd_pkg::in_word_t w;
		w.op = ptpd_pkg::OP_XFORM;
		w.entry_index = 4'($urandom);
		w.entry_value = $urandom;
		w.point_x = x;
		w.point_y = y;
		w.point_z = z;
		send_word(w);
	endtask

	// Receiver stall pattern; the long hold forces the queue to fill.
	always @(posedge clk) begin
		if (long_hold)
			res_stall <= 1'b1;
		else
			case ($urandom_range(0, 9))
				0, 1, 2: res_stall <= 1'b1;
				default: res_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0);
			endcase
	end

	initial begin
		repeat (200) @(posedge clk);
		long_hold <= 1'b1;
		repeat (300) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Identity matrix on corner points, then w made zero, then saturation.
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
		send_point(32'sh0001_0000, -32'sh0001_0000, 32'sd1);
		send_load(15, 32'sd0);
		send_point(32'sd5, 32'sd6, 32'sd7);
		send_load(15, 32'sd1);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh4000_0000);
		send_load(12, 32'sh7FFF_FFFF);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd3);
		send_load(12, 32'sh8000_0000);
		send_load(0, 32'sh8000_0000);
		send_point(32'sh8000_0000, 32'sd1, -32'sd1);
		send_load(3, 32'sh7FFF_FFFF);
		send_point(32'sd0, 32'sd0, 32'sd0);
		for (int i = 0; i < 16; i++)
			send_load(i, (i % 5 == 0) ? 32'sh0001_0000 : 32'sd0);
		idle_cycles(1);
		for (int n = 0; n < RANDOM_WORDS; ) begin
			int burst;
			burst = $urandom_range(1, 30);
			for (int b = 0; b < burst; b++, n++) begin
				if ($urandom_range(0, 9) == 0)
					send_load($urandom_range(0, 15), rand_value());
				else if ($urandom_range(0, 40) == 0)
					// Zero x, y, z make w the translation entry alone.
					send_point(32'sd0, 32'sd0, 32'sd0);
				else
					send_point(rand_value(), rand_value(), rand_value());
			end
			if ($urandom_range(0, 2) == 0)
				idle_cycles($urandom_range(1, 12));
			if (n > RANDOM_WORDS / 2 && n < RANDOM_WORDS / 2 + 31) begin
				pt_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end
		pt_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d transformed points across random matrix loads,", points_seen);
		$display("including %0d saturated and %0d zero-w results.", sat_seen, wz_seen);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
